// File: sv/sdcf_pkg.sv
// ----------------------------------------------------------------------------
// sdcf_pkg
// Shared types and constants for the SD SPI-mode command frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sdcf_pkg;

  // frame timing
  localparam int unsigned POLL_TRIES = 10;
  localparam int unsigned FILL_SLOTS = 4;

  localparam int unsigned CNT_W  = 4;
  localparam int unsigned POLL_W = 4;

  // fixed bytes of a frame
  localparam logic [7:0] PREFIX_CMD = 8'h77;
  localparam logic [7:0] PREFIX_CRC = 8'h65;
  localparam logic [7:0] STOP_CMD   = 8'h4C;
  localparam logic [7:0] FILLER     = 8'hFF;
  localparam logic [7:0] APP_FLAG   = 8'h80;
  localparam logic [7:0] CMD_MASK   = 8'h7F;

  // beat kinds
  localparam logic OP_START = 1'b0;
  localparam logic OP_SLOT  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FILL,
    PH_CMD,
    PH_ARG,
    PH_CRC,
    PH_STUFF,
    PH_POLL
  } phase_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  cmd_byte;
    logic [31:0] argument;
    logic [7:0]  crc_byte;
    logic [7:0]  rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic       slot_request;
    logic [7:0] tx_byte;
    logic       cs_pulse;
    logic       done_res;
    logic [7:0] reply;
    logic       busy_res;
  } out_beat_t;

endpackage

`default_nettype wire

// File: sv/sd_spi_command_frame_engine_core.sv
// ----------------------------------------------------------------------------
// sd_spi_command_frame_engine_core
// Sequences one SD SPI-mode command transaction, one byte slot per beat.
// ----------------------------------------------------------------------------
// Each input beat (a start request or a finished byte slot) yields exactly
// one result beat that says whether to clock another slot, which byte to send,
// whether to pulse chip select first, and whether the transaction is done.
// The block takes one input beat per cycle while the result register is free
// or being drained: the result is formed by the frame sequencer logic in the
// cycle of acceptance and appears from the result register on the next cycle.
// While that register holds an untaken result, a new beat is accepted only in
// the cycle the result is taken.
`default_nettype none

module sd_spi_command_frame_engine_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sdcf_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sdcf_pkg::out_beat_t      out_data_o
);
  import sdcf_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  slot_count_q, slot_count_d;
  logic [POLL_W-1:0] poll_left_q, poll_left_d;
  logic              in_prefix_q, in_prefix_d;
  logic [7:0]        saved_command_q, saved_command_d;
  logic [31:0]       saved_argument_q, saved_argument_d;
  logic [7:0]        saved_crc_q, saved_crc_d;
  logic              out_valid_q;
  out_beat_t         out_data_q, res_d;

  logic              accept;
  logic [7:0]        frame_cmd;
  logic [31:0]       frame_arg;
  logic [7:0]        frame_crc;

  // take a beat whenever the result register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // bytes of the frame in flight
  assign frame_cmd = in_prefix_q ? PREFIX_CMD : (saved_command_q & CMD_MASK);
  assign frame_arg = in_prefix_q ? 32'd0 : saved_argument_q;
  assign frame_crc = in_prefix_q ? PREFIX_CRC : saved_crc_q;

  // frame sequencer: next state and the result of this beat
  always_comb begin
    phase_d          = phase_q;
    slot_count_d     = slot_count_q;
    poll_left_d      = poll_left_q;
    in_prefix_d      = in_prefix_q;
    saved_command_d  = saved_command_q;
    saved_argument_d = saved_argument_q;
    saved_crc_d      = saved_crc_q;
    res_d            = '0;

    if (in_data_i.command == OP_START) begin
      if (phase_q != PH_IDLE) begin
        res_d.busy_res = 1'b1;
      end else begin
        saved_command_d  = in_data_i.cmd_byte;
        saved_argument_d = in_data_i.argument;
        saved_crc_d      = in_data_i.crc_byte;
        in_prefix_d      = (in_data_i.cmd_byte & APP_FLAG) != 8'd0;
        phase_d          = PH_FILL;
        slot_count_d     = '0;
        poll_left_d      = '0;
        res_d            = '{slot_request: 1'b1, tx_byte: FILLER, cs_pulse: 1'b1,
                             done_res: 1'b0, reply: 8'd0, busy_res: 1'b1};
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          res_d = '0;
        end
        PH_FILL: begin
          slot_count_d         = slot_count_q + CNT_W'(1);
          res_d.slot_request   = 1'b1;
          res_d.busy_res       = 1'b1;
          if (slot_count_d < CNT_W'(FILL_SLOTS)) begin
            res_d.tx_byte = FILLER;
          end else begin
            phase_d       = PH_CMD;
            res_d.tx_byte = frame_cmd;
          end
        end
        PH_CMD: begin
          phase_d            = PH_ARG;
          slot_count_d       = '0;
          res_d.slot_request = 1'b1;
          res_d.busy_res     = 1'b1;
          res_d.tx_byte      = frame_arg[31:24];
        end
        PH_ARG: begin
          slot_count_d       = slot_count_q + CNT_W'(1);
          res_d.slot_request = 1'b1;
          res_d.busy_res     = 1'b1;
          // remaining argument bytes, most significant first
          case (slot_count_d)
            CNT_W'(1): res_d.tx_byte = frame_arg[23:16];
            CNT_W'(2): res_d.tx_byte = frame_arg[15:8];
            CNT_W'(3): res_d.tx_byte = frame_arg[7:0];
            default: begin
              phase_d       = PH_CRC;
              res_d.tx_byte = frame_crc;
            end
          endcase
        end
        PH_CRC: begin
          res_d.slot_request = 1'b1;
          res_d.busy_res     = 1'b1;
          res_d.tx_byte      = FILLER;
          // stop-transmission needs one stuff slot before the reply
          if (frame_cmd == STOP_CMD) begin
            phase_d = PH_STUFF;
          end else begin
            phase_d     = PH_POLL;
            poll_left_d = POLL_W'(POLL_TRIES);
          end
        end
        PH_STUFF: begin
          phase_d            = PH_POLL;
          poll_left_d        = POLL_W'(POLL_TRIES);
          res_d.slot_request = 1'b1;
          res_d.busy_res     = 1'b1;
          res_d.tx_byte      = FILLER;
        end
        PH_POLL: begin
          if (poll_left_q != '0) begin
            poll_left_d = poll_left_q - POLL_W'(1);
          end
          if (in_data_i.rx_byte[7] && (poll_left_d != '0)) begin
            res_d.slot_request = 1'b1;
            res_d.busy_res     = 1'b1;
            res_d.tx_byte      = FILLER;
          end else if (in_prefix_q && (in_data_i.rx_byte <= 8'd1)) begin
            // prefix accepted: start the main frame
            in_prefix_d  = 1'b0;
            phase_d      = PH_FILL;
            slot_count_d = '0;
            poll_left_d  = '0;
            res_d        = '{slot_request: 1'b1, tx_byte: FILLER, cs_pulse: 1'b1,
                             done_res: 1'b0, reply: 8'd0, busy_res: 1'b1};
          end else begin
            phase_d        = PH_IDLE;
            in_prefix_d    = 1'b0;
            poll_left_d    = '0;
            slot_count_d   = '0;
            res_d.done_res = 1'b1;
            res_d.reply    = in_data_i.rx_byte;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_IDLE;
      slot_count_q     <= '0;
      poll_left_q      <= '0;
      in_prefix_q      <= 1'b0;
      saved_command_q  <= '0;
      saved_argument_q <= '0;
      saved_crc_q      <= '0;
    end else if (accept) begin
      phase_q          <= phase_d;
      slot_count_q     <= slot_count_d;
      poll_left_q      <= poll_left_d;
      in_prefix_q      <= in_prefix_d;
      saved_command_q  <= saved_command_d;
      saved_argument_q <= saved_argument_d;
      saved_crc_q      <= saved_crc_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: sv/sdcf_checker.sv
// ----------------------------------------------------------------------------
// sdcf_checker
// Port-level checks on the command frame engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sdcf_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire sdcf_pkg::in_beat_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire sdcf_pkg::out_beat_t out_data_o
);
  import sdcf_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // every accepted beat shows a result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // a finished transaction is no longer busy and asks for no slot
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |->
      !out_data_o.busy_res && !out_data_o.slot_request && !out_data_o.cs_pulse)
    else $error("done result with busy or slot request");

  // chip select pulses only ahead of a filler slot
  a_cs_filler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cs_pulse |->
      out_data_o.slot_request && (out_data_o.tx_byte == FILLER) && out_data_o.busy_res)
    else $error("chip select pulse outside a frame start");

  // no slot means nothing to send and no reply unless done
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.slot_request |->
      (out_data_o.tx_byte == 8'd0) && (out_data_o.done_res || (out_data_o.reply == 8'd0)))
    else $error("idle result carries data");

endmodule

bind sd_spi_command_frame_engine_core sdcf_checker u_sdcf_checker (.*);

`default_nettype wire

// File: tb/frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker
// Watches both channels of the SD SPI command frame engine, predicts the
// result beat of every accepted input beat and compares it field by field.
// ----------------------------------------------------------------------------
module frame_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  sdcf_pkg::in_beat_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  sdcf_pkg::out_beat_t out_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  import sdcf_pkg::*;

  localparam int unsigned SHOWN_MISSES = 10;

  // frame sequencer state as the card transaction sees it
  phase_e      ph;
  logic [3:0]  slot_cnt;
  logic [3:0]  polls_left;
  logic        prefix_active;
  logic [7:0]  held_cmd;
  logic [31:0] held_arg;
  logic [7:0]  held_crc;

  out_beat_t   due_beats[$];
  int unsigned mismatches;

  function automatic logic [7:0] sent_cmd();
    return prefix_active ? PREFIX_CMD : (held_cmd & CMD_MASK);
  endfunction

  function automatic logic [31:0] sent_arg();
    return prefix_active ? 32'h0 : held_arg;
  endfunction

  function automatic out_beat_t slot_beat(input logic [7:0] tx, input logic cs);
    out_beat_t r;
    r = '0;
    r.slot_request = 1'b1;
    r.tx_byte      = tx;
    r.cs_pulse     = cs;
    r.busy_res     = 1'b1;
    return r;
  endfunction

  function automatic out_beat_t open_frame();
    ph         = PH_FILL;
    slot_cnt   = '0;
    polls_left = '0;
    return slot_beat(FILLER, 1'b1);
  endfunction

  function automatic out_beat_t open_poll();
    ph         = PH_POLL;
    polls_left = POLL_TRIES[3:0];
    return slot_beat(FILLER, 1'b0);
  endfunction

  // next result beat for one input beat, advancing the transaction
  function automatic out_beat_t advance_frame(input in_beat_t b);
    out_beat_t r;
    r = '0;
    if (b.command == OP_START) begin
      // a start while a transaction runs is dropped
      if (ph != PH_IDLE) begin
        r.busy_res = 1'b1;
        return r;
      end
      held_cmd      = b.cmd_byte;
      held_arg      = b.argument;
      held_crc      = b.crc_byte;
      prefix_active = (b.cmd_byte & APP_FLAG) != 8'h00;
      return open_frame();
    end
    // slot finished with nothing running
    if (ph == PH_IDLE) return r;
    case (ph)
      PH_FILL: begin
        slot_cnt = slot_cnt + 4'd1;
        if (slot_cnt < FILL_SLOTS) begin
          r = slot_beat(FILLER, 1'b0);
        end else begin
          ph = PH_CMD;
          r  = slot_beat(sent_cmd(), 1'b0);
        end
      end
      PH_CMD: begin
        ph       = PH_ARG;
        slot_cnt = '0;
        r        = slot_beat(sent_arg()[31:24], 1'b0);
      end
      PH_ARG: begin
        slot_cnt = slot_cnt + 4'd1;
        if (slot_cnt < 4'd4) begin
          r = slot_beat(8'(sent_arg() >> (8 * (3 - int'(slot_cnt)))), 1'b0);
        end else begin
          ph = PH_CRC;
          r  = slot_beat(prefix_active ? PREFIX_CRC : held_crc, 1'b0);
        end
      end
      PH_CRC: begin
        // stop transmission needs one stuff byte before the reply
        if (sent_cmd() == STOP_CMD) begin
          ph = PH_STUFF;
          r  = slot_beat(FILLER, 1'b0);
        end else begin
          r = open_poll();
        end
      end
      PH_STUFF: r = open_poll();
      default: begin
        if (polls_left != 4'd0) polls_left = polls_left - 4'd1;
        if (b.rx_byte[7] && polls_left != 4'd0) begin
          r = slot_beat(FILLER, 1'b0);
        end else if (prefix_active && b.rx_byte <= 8'd1) begin
          // prefix accepted, main frame follows at once
          prefix_active = 1'b0;
          r = open_frame();
        end else begin
          ph            = PH_IDLE;
          prefix_active = 1'b0;
          polls_left    = '0;
          slot_cnt      = '0;
          r.done_res    = 1'b1;
          r.reply       = b.rx_byte;
        end
      end
    endcase
    return r;
  endfunction

  task automatic log_miss(input string why, input out_beat_t want, input out_beat_t got);
    mismatches = mismatches + 1;
    if (mismatches <= SHOWN_MISSES)
      $display("%0t %s: want req=%0b tx=%h cs=%0b done=%0b reply=%h busy=%0b",
               $realtime, why, want.slot_request, want.tx_byte, want.cs_pulse,
               want.done_res, want.reply, want.busy_res,
               "\n    got req=%0b tx=%h cs=%0b done=%0b reply=%h busy=%0b",
               got.slot_request, got.tx_byte, got.cs_pulse, got.done_res,
               got.reply, got.busy_res);
  endtask

  // result beats first, then the beat that enters in the same cycle
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      ph            = PH_IDLE;
      slot_cnt      = '0;
      polls_left    = '0;
      prefix_active = 1'b0;
      held_cmd      = '0;
      held_arg      = '0;
      held_crc      = '0;
      mismatches    = 0;
      due_beats.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_beats.size() == 0) begin
          log_miss("result beat with nothing outstanding", '0, out_data_i);
        end else begin
          want = due_beats.pop_front();
          if (out_data_i.slot_request !== want.slot_request ||
              out_data_i.tx_byte      !== want.tx_byte      ||
              out_data_i.cs_pulse     !== want.cs_pulse     ||
              out_data_i.done_res     !== want.done_res     ||
              out_data_i.reply        !== want.reply        ||
              out_data_i.busy_res     !== want.busy_res)
            log_miss("result beat mismatch", want, out_data_i);
        end
      end
      if (in_valid_i && in_ready_i) due_beats.push_back(advance_frame(in_data_i));
      fail_count_o <= mismatches;
      pending_o    <= due_beats.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives whole SD SPI command transactions (with and without the application
// prefix, stop transmission, polling runs and exhaustion) plus dropped and
// broken beats into the frame engine, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import sdcf_pkg::*;

  localparam int unsigned ITEM_TARGET = 600;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_SLOTS = 30;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned NO_CUT      = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_beat_t    in_data = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned beats_sent = 0;
  int unsigned cut_left = NO_CUT;
  int unsigned cycle_count = 0;
  int unsigned txn_count = 0;
  logic        burst = 1'b0;

  sd_spi_command_frame_engine_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  frame_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none in burst stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic in_beat_t start_with(input logic [7:0] cmd, input logic [31:0] arg,
                                          input logic [7:0] crc);
    in_beat_t b;
    b.command  = OP_START;
    b.cmd_byte = cmd;
    b.argument = arg;
    b.crc_byte = crc;
    b.rx_byte  = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic in_beat_t slot_with(input logic [7:0] rx);
    in_beat_t b;
    b.command  = OP_SLOT;
    b.cmd_byte = 8'($urandom_range(0, 255));
    b.argument = $urandom();
    b.crc_byte = 8'($urandom_range(0, 255));
    b.rx_byte  = rx;
    return b;
  endfunction

  // one beat on the input channel, valid held until taken
  task automatic send_beat(input in_beat_t b);
    int unsigned gap;
    gap = pick_gap();
    beats_sent = beats_sent + 1;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // beat of a planned transaction, dropped once a broken sequence is cut off
  task automatic plan_beat(input in_beat_t b);
    if (cut_left == 0) return;
    cut_left = cut_left - 1;
    send_beat(b);
  endtask

  // hold the sender until every result beat is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // filler, command, argument, crc, optional stuff, then the reply polls
  task automatic send_frame(input logic stop, input int unsigned polls,
                            input logic [7:0] reply);
    int unsigned n_slots;
    n_slots = FILL_SLOTS + 6 + (stop ? 1 : 0);
    for (int unsigned i = 0; i < n_slots; i++) begin
      if ($urandom_range(0, 24) == 0)
        send_beat(start_with(8'($urandom_range(0, 255)), $urandom(),
                             8'($urandom_range(0, 255))));
      plan_beat(slot_with(8'($urandom_range(0, 255))));
    end
    for (int unsigned i = 1; i < polls; i++)
      plan_beat(slot_with(APP_FLAG | 8'($urandom_range(0, 127))));
    plan_beat(slot_with(reply));
  endtask

  task automatic random_transaction();
    logic [7:0]  cmd;
    logic [31:0] arg;
    int unsigned polls;
    int unsigned pick;
    logic [7:0]  reply;
    logic        go_on;
    logic        broken;
    cmd = 8'($urandom_range(0, 127));
    if ($urandom_range(0, 5) == 0) cmd = STOP_CMD;
    cmd[7] = ($urandom_range(0, 99) < 35);
    case ($urandom_range(0, 5))
      0: arg = 32'h0;
      1: arg = 32'hFFFF_FFFF;
      default: arg = $urandom();
    endcase
    broken   = ($urandom_range(0, 9) == 0);
    cut_left = broken ? $urandom_range(1, 20) : NO_CUT;
    burst    = ($urandom_range(0, 4) == 0);
    plan_beat(start_with(cmd, arg, 8'($urandom_range(0, 255))));
    go_on = 1'b1;
    // application prefix: accepted, refused, or never answered
    if (cmd[7]) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        polls = $urandom_range(1, POLL_TRIES);
        reply = 8'($urandom_range(0, 1));
      end else if (pick < 16) begin
        polls = $urandom_range(1, POLL_TRIES);
        reply = 8'($urandom_range(2, 127));
      end else begin
        polls = POLL_TRIES;
        reply = APP_FLAG | 8'($urandom_range(0, 127));
      end
      send_frame(1'b0, polls, reply);
      go_on = (reply <= 8'd1);
    end
    if (go_on) begin
      if ($urandom_range(0, 9) == 0) begin
        polls = POLL_TRIES;
        reply = APP_FLAG | 8'($urandom_range(0, 127));
      end else begin
        polls = $urandom_range(1, POLL_TRIES);
        reply = 8'($urandom_range(0, 127));
      end
      send_frame((cmd & CMD_MASK) == STOP_CMD, polls, reply);
    end
    // broken sequence: stray starts, then quiet slots bring it back to idle
    if (broken) begin
      repeat ($urandom_range(0, 2))
        send_beat(start_with(8'($urandom_range(0, 255)), $urandom(),
                             8'($urandom_range(0, 255))));
      repeat (DRAIN_SLOTS) send_beat(slot_with(8'h00));
    end
    cut_left = NO_CUT;
    burst    = 1'b0;
  endtask

  // output side stalls
  initial begin
    int unsigned gap;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: slot while idle, prefixed stop transmission at full-scale
    // fields with a dropped start, prefix accepted with a zero reply
    send_beat(slot_with(8'hFF));
    plan_beat(start_with(APP_FLAG | STOP_CMD, 32'hFFFF_FFFF, 8'hFF));
    send_beat(start_with(8'h00, 32'h0, 8'h00));
    send_frame(1'b0, 1, 8'h00);
    send_frame(1'b1, 1, 8'h00);
    wait_drained();

    // random transactions with idle-slot noise and periodic full drains
    while (beats_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) send_beat(slot_with(8'($urandom_range(0, 255))));
      random_transaction();
      txn_count = txn_count + 1;
      if (txn_count % 8 == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sdcf_pkg.sv
sv/sd_spi_command_frame_engine_core.sv
sv/sdcf_checker.sv
tb/frame_checker.sv
tb/testbench.sv
